// ===== hw/rtl/ufs_pkg.sv =====
package ufs_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned MAX_BYTES   = 6;

   localparam logic [7:0] REPL_B0   = 8'hEF;
   localparam logic [7:0] REPL_B1   = 8'hBF;
   localparam logic [7:0] REPL_B2   = 8'hBD;
   localparam logic [7:0] LEAD_E0   = 8'hE0;
   localparam logic [7:0] LEAD_ED   = 8'hED;
   localparam logic [7:0] LEAD_F0   = 8'hF0;
   localparam logic [7:0] LEAD_F4   = 8'hF4;
   localparam logic [7:0] CONT_LO   = 8'h80;
   localparam logic [7:0] CONT_HI   = 8'hBF;
   localparam logic [7:0] E0_LO     = 8'hA0;
   localparam logic [7:0] ED_HI     = 8'h9F;
   localparam logic [7:0] F0_LO     = 8'h90;
   localparam logic [7:0] F4_HI     = 8'h8F;

   typedef enum logic [1:0] {
      CLS_ASCII,
      CLS_LEAD,
      CLS_BAD
   } byte_class_type;

   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [2:0]                count;
      logic                      clean;
   } cmd_type;

   function automatic byte_class_type classify(input logic [7:0] b);
      byte_class_type cls;
      if (b < 8'h80) begin
         cls = CLS_ASCII;
      end else if (b inside {[8'hC2:8'hF4]}) begin
         cls = CLS_LEAD;
      end else begin
         cls = CLS_BAD;
      end
      return cls;
   endfunction

   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      if (b inside {[8'hC2:8'hDF]}) begin
         len = 3'd2;
      end else if (b inside {[8'hE0:8'hEF]}) begin
         len = 3'd3;
      end else begin
         len = 3'd4;
      end
      return len;
   endfunction

endpackage

// ===== hw/rtl/ufs_if.sv =====
interface ufs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_stream;

   modport source (output valid, output in_byte, output end_of_stream, input ready);
   modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface ufs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       stream_clean;

   modport source (output valid, output out_byte, output run_last, output stream_clean,
                   input ready);
   modport sink   (input valid, input out_byte, input run_last, input stream_clean,
                   output ready);
endinterface

// ===== hw/rtl/ufs_front.sv =====
module ufs_front (
   input  logic            clock,
   input  logic            reset,
   ufs_req_if.sink         req_if,
   input  logic            q_full,
   output logic            q_push,
   output ufs_pkg::cmd_type q_data
);
   import ufs_pkg::*;

   logic [2:0][7:0] pend_ff, pend_in;
   logic [1:0]      pcnt_ff, pcnt_in;
   logic [2:0]      len_ff, len_in;
   logic            clean_ff, clean_in;
   logic            cln;
   logic [2:0]      n;
   logic            fresh;
   logic [7:0]      lo, hi, b;
   logic            accept;
   cmd_type         cmd;

   assign b            = req_if.in_byte;
   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      cmd     = '0;
      n       = '0;
      cln     = clean_ff;
      pend_in = pend_ff;
      pcnt_in = pcnt_ff;
      len_in  = len_ff;
      fresh   = 1'b0;
      lo      = CONT_LO;
      hi      = CONT_HI;
      if (pcnt_ff == 2'd1) begin
         if (pend_ff[0] == LEAD_E0) lo = E0_LO;
         if (pend_ff[0] == LEAD_ED) hi = ED_HI;
         if (pend_ff[0] == LEAD_F0) lo = F0_LO;
         if (pend_ff[0] == LEAD_F4) hi = F4_HI;
      end
      if (pcnt_ff == 2'd0) begin
         fresh = 1'b1;
      end else if (b < lo || b > hi) begin
         cmd.bytes[n]        = REPL_B0;
         cmd.bytes[n + 3'd1] = REPL_B1;
         cmd.bytes[n + 3'd2] = REPL_B2;
         n       = n + 3'd3;
         cln     = 1'b0;
         pcnt_in = '0;
         len_in  = '0;
         fresh   = 1'b1;
      end else if (({1'b0, pcnt_ff} + 3'd1) >= len_ff || pcnt_ff == 2'd3) begin
         for (int k = 0; k < 3; k++) begin
            if (2'(k) < pcnt_ff) begin
               cmd.bytes[n] = pend_ff[2'(k)];
               n = n + 3'd1;
            end
         end
         cmd.bytes[n] = b;
         n       = n + 3'd1;
         pcnt_in = '0;
         len_in  = '0;
      end else begin
         pend_in[pcnt_ff] = b;
         pcnt_in = pcnt_ff + 2'd1;
      end
      if (fresh) begin
         case (classify(b))
            CLS_ASCII: begin
               cmd.bytes[n] = b;
               n = n + 3'd1;
            end
            CLS_LEAD: begin
               pend_in[0] = b;
               pcnt_in    = 2'd1;
               len_in     = lead_length(b);
            end
            default: begin
               cmd.bytes[n]        = REPL_B0;
               cmd.bytes[n + 3'd1] = REPL_B1;
               cmd.bytes[n + 3'd2] = REPL_B2;
               n   = n + 3'd3;
               cln = 1'b0;
            end
         endcase
      end
      if (req_if.end_of_stream && pcnt_in != 2'd0) begin
         cmd.bytes[n]        = REPL_B0;
         cmd.bytes[n + 3'd1] = REPL_B1;
         cmd.bytes[n + 3'd2] = REPL_B2;
         n       = n + 3'd3;
         cln     = 1'b0;
         pcnt_in = '0;
         len_in  = '0;
      end
      cmd.count = n;
      cmd.clean = cln;
      clean_in  = req_if.end_of_stream ? 1'b1 : cln;
   end

   assign q_push = accept && (n != 3'd0);
   assign q_data = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         pcnt_ff  <= '0;
         len_ff   <= '0;
         clean_ff <= 1'b1;
      end else if (accept) begin
         pcnt_ff  <= pcnt_in;
         len_ff   <= len_in;
         clean_ff <= clean_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
   end

endmodule

// ===== hw/rtl/ufs_queue.sv =====
module ufs_queue #(
   parameter int unsigned DEPTH = ufs_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ufs_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output ufs_pkg::cmd_type pop_data
);
   import ufs_pkg::*;

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   cmd_type         mem [DEPTH];
   logic [PtrW-1:0] wptr_ff, rptr_ff;
   logic [CntW-1:0] cnt_ff;
   logic            do_push, do_pop;

   assign full      = (cnt_ff == CntW'(DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;
   assign pop_data  = mem[rptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (do_push) begin
            wptr_ff <= (wptr_ff == PtrW'(DEPTH - 1)) ? '0 : wptr_ff + PtrW'(1);
         end
         if (do_pop) begin
            rptr_ff <= (rptr_ff == PtrW'(DEPTH - 1)) ? '0 : rptr_ff + PtrW'(1);
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + CntW'(1);
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - CntW'(1);
         end
      end
   end

endmodule

// ===== hw/rtl/ufs_back.sv =====
module ufs_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  ufs_pkg::cmd_type q_data,
   output logic             q_pop,
   ufs_rsp_if.source        rsp_if
);
   import ufs_pkg::*;

   cmd_type    cur_ff;
   logic       cur_vld_ff;
   logic [2:0] idx_ff;
   logic       rsp_vld_ff;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       clean_ff;
   logic       out_load, last, cur_take;

   assign last     = (idx_ff == cur_ff.count - 3'd1);
   assign out_load = cur_vld_ff && (!rsp_vld_ff || rsp_if.ready);
   assign cur_take = !cur_vld_ff || (out_load && last);
   assign q_pop    = cur_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff <= 1'b0;
         idx_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (cur_take) begin
            cur_vld_ff <= q_valid;
            idx_ff     <= '0;
         end else if (out_load) begin
            idx_ff <= idx_ff + 3'd1;
         end
         if (out_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cur_take) begin
         cur_ff <= q_data;
      end
      if (out_load) begin
         byte_ff  <= cur_ff.bytes[idx_ff];
         last_ff  <= last;
         clean_ff <= cur_ff.clean;
      end
   end

   assign rsp_if.valid        = rsp_vld_ff;
   assign rsp_if.out_byte     = byte_ff;
   assign rsp_if.run_last     = last_ff;
   assign rsp_if.stream_clean = clean_ff;

endmodule

// ===== hw/rtl/utf8_sanitizer.sv =====
// UTF-8 sanitizer.
// req_if: one raw byte per transfer, end_of_stream set on the final byte of a text.
// rsp_if: sanitized bytes, one per transfer. run_last marks the last byte caused
//   by one request transfer; stream_clean is 1 while no U+FFFD (EF BF BD) has been
//   emitted in the current text, and on the last byte of the end_of_stream
//   request it is the verdict for the whole text.
// A request byte yields 0 to 6 response bytes. Bytes of an incomplete sequence
//   are held (up to three) and released when the sequence completes.
// Each byte goes through the queue, the command register and the output register.
// Throughput: one request per cycle unless the queue is full; the response side moves
//   one byte per cycle while rsp_if.ready is high, so sustained rate is set by the
//   output byte count. A QUEUE_DEPTH-entry command queue links classifier and serializer.
// Reset: discards held bytes and queued commands, clears output valid; stream_clean starts at 1.
// Response stall: the output register holds its byte; the queue fills, and
//   req_if.ready drops only once the queue is full.
module utf8_sanitizer #(
   parameter int unsigned QUEUE_DEPTH = ufs_pkg::QUEUE_DEPTH
) (
   input logic       clock,
   input logic       reset,
   ufs_req_if.sink   req_if,
   ufs_rsp_if.source rsp_if
);
   import ufs_pkg::*;

   logic    q_full, q_push, q_pop, q_valid;
   cmd_type q_wdata, q_rdata;

   ufs_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_wdata)
   );

   ufs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_rdata)
   );

   ufs_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_data  (q_rdata),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );

endmodule

// ===== hw/rtl/ufs_checker.sv =====
module ufs_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic       run_last,
   input logic       stream_clean
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(out_byte) && $stable(run_last)
                                  && $stable(stream_clean))
      else $error("rsp payload changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_legal_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> out_byte < 8'hF5 && out_byte != 8'hC0 && out_byte != 8'hC1)
      else $error("illegal UTF-8 byte on output");

endmodule

bind utf8_sanitizer ufs_checker u_ufs_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .out_byte     (rsp_if.out_byte),
   .run_last     (rsp_if.run_last),
   .stream_clean (rsp_if.stream_clean)
);
